// ===== rtl/core/brs_pkg.sv =====
package brs_pkg;

  // Field widths fixed by the item formats
  localparam int unsigned POS_W       = 10;
  localparam int unsigned COLOUR_W    = 8;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 11;
  localparam int unsigned SRC_REG_W   = 9;
  localparam int unsigned TGT_REG_W   = 11;

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_WIDTH  = 2'd0,
    CFG_SOURCE_HEIGHT = 2'd1,
    CFG_TARGET_WIDTH  = 2'd2,
    CFG_TARGET_HEIGHT = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic                req_type;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic [COLOUR_W-1:0] pixel_red;
    logic [COLOUR_W-1:0] pixel_green;
    logic [COLOUR_W-1:0] pixel_blue;
  } in_item_t;

  typedef struct packed {
    logic [COLOUR_W-1:0] out_red;
    logic [COLOUR_W-1:0] out_green;
    logic [COLOUR_W-1:0] out_blue;
    logic                status;
  } out_item_t;

endpackage

// ===== rtl/core/brs_ram.sv =====
module brs_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/bilinear_rgb_image_scaler_unit.sv =====
// Channel  | Direction | Handshake              | Payload
// in       | input     | in_valid_i/in_stall_o  | in_item_i  (brs_pkg::in_item_t)
// out      | output    | out_valid_o/out_stall_i| out_item_o (brs_pkg::out_item_t)
// cfg      | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// A sample item makes four neighbour reads on one single-port image memory, a
// load item at most one write; the memory side takes the next item only when
// the current one is on its last step. A sample passes the divider (one
// quotient bit per stage), the memory reads, the blend and the output register.
// Reset clears control state and sets the sizes to 256x256 source, 1024x1024
// target; the image memory is not cleared. A stalled output freezes the memory
// side; the input takes items until one must wait at the end of the divider.
module bilinear_rgb_image_scaler_unit
  import brs_pkg::*;
#(
  parameter int unsigned MAX_SOURCE_WIDTH  = 256,
  parameter int unsigned MAX_SOURCE_HEIGHT = 256,
  parameter int unsigned MAX_TARGET_DIM    = 1024,
  parameter int unsigned FRACTION_BITS     = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned F    = FRACTION_BITS;
  localparam int unsigned SWW  = $clog2(MAX_SOURCE_WIDTH + 1);
  localparam int unsigned SHW  = $clog2(MAX_SOURCE_HEIGHT + 1);
  localparam int unsigned TDW  = $clog2(MAX_TARGET_DIM + 1);
  localparam int unsigned IW   = (SWW > SHW) ? SWW : SHW;   // integer part width
  localparam int unsigned QW   = IW + F;                    // quotient width
  localparam int unsigned RW   = TDW + 1;                   // remainder / divisor width
  localparam int unsigned PW   = POS_W + 1 + IW;            // (2d+1)*src width
  localparam int unsigned XW   = $clog2(MAX_SOURCE_WIDTH);
  localparam int unsigned YW   = $clog2(MAX_SOURCE_HEIGHT);
  localparam int unsigned DEPTH = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned PIX_W = 3 * COLOUR_W;
  localparam int unsigned WW   = 2 * F + 1;                 // weight width
  localparam int unsigned AC   = COLOUR_W + WW + 2;         // accumulator width
  localparam int unsigned RNDW = AC - 2 * F;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [SRC_REG_W-1:0] src_w_q, src_h_q;
  logic [TGT_REG_W-1:0] tgt_w_q, tgt_h_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= SRC_REG_W'(256);
      src_h_q <= SRC_REG_W'(256);
      tgt_w_q <= TGT_REG_W'(1024);
      tgt_h_q <= TGT_REG_W'(1024);
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SOURCE_WIDTH:  src_w_q <= cfg_data_i[SRC_REG_W-1:0];
        CFG_SOURCE_HEIGHT: src_h_q <= cfg_data_i[SRC_REG_W-1:0];
        CFG_TARGET_WIDTH:  tgt_w_q <= cfg_data_i[TGT_REG_W-1:0];
        CFG_TARGET_HEIGHT: tgt_h_q <= cfg_data_i[TGT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective sizes: zero acts as one, oversize acts as the maximum
  logic [SWW-1:0] sw_eff;
  logic [SHW-1:0] sh_eff;
  logic [TDW-1:0] tw_eff, th_eff;

  always_comb begin
    if (src_w_q == '0) sw_eff = SWW'(1);
    else if (32'(src_w_q) > 32'(MAX_SOURCE_WIDTH)) sw_eff = SWW'(MAX_SOURCE_WIDTH);
    else sw_eff = SWW'(src_w_q);
    if (src_h_q == '0) sh_eff = SHW'(1);
    else if (32'(src_h_q) > 32'(MAX_SOURCE_HEIGHT)) sh_eff = SHW'(MAX_SOURCE_HEIGHT);
    else sh_eff = SHW'(src_h_q);
    if (tgt_w_q == '0) tw_eff = TDW'(1);
    else if (32'(tgt_w_q) > 32'(MAX_TARGET_DIM)) tw_eff = TDW'(MAX_TARGET_DIM);
    else tw_eff = TDW'(tgt_w_q);
    if (tgt_h_q == '0) th_eff = TDW'(1);
    else if (32'(tgt_h_q) > 32'(MAX_TARGET_DIM)) th_eff = TDW'(MAX_TARGET_DIM);
    else th_eff = TDW'(tgt_h_q);
  end

  // Divisors 2*dst: the user must keep them constant while items are in flight; the block has no guard
  logic [RW-1:0] div_x, div_y;
  assign div_x = {tw_eff, 1'b0};
  assign div_y = {th_eff, 1'b0};

  // ---------------------------------------------------------------------------
  // Source-position divider: one quotient bit per stage, x and y side by side
  // ---------------------------------------------------------------------------
  logic            pv_q   [0:QW];
  in_item_t        pitem_q[0:QW];
  logic [RW-1:0]   rx_q   [0:QW];
  logic [QW-1:0]   lx_q   [0:QW];
  logic [RW-1:0]   ry_q   [0:QW];
  logic [QW-1:0]   ly_q   [0:QW];
  logic [RW-1:0]   rx_d   [1:QW];
  logic [QW-1:0]   lx_d   [1:QW];
  logic [RW-1:0]   ry_d   [1:QW];
  logic [QW-1:0]   ly_d   [1:QW];
  logic [RW:0]     tx     [1:QW];
  logic [RW:0]     ty     [1:QW];

  logic            adv;
  logic            take;

  logic [PW-1:0]      prod_x, prod_y;
  logic [QW+RW-1:0]   ext_x, ext_y;

  assign in_stall_o = !adv;

  // Numerator ((2d+1)*src) << F, split into starting remainder and low bits
  always_comb begin
    prod_x = PW'({in_item_i.pos_x, 1'b1}) * PW'(sw_eff);
    prod_y = PW'({in_item_i.pos_y, 1'b1}) * PW'(sh_eff);
    ext_x  = (QW+RW)'(prod_x) << F;
    ext_y  = (QW+RW)'(prod_y) << F;
  end

  always_comb begin
    for (int i = 1; i <= QW; i++) begin
      tx[i] = {rx_q[i-1], lx_q[i-1][QW-1]};
      ty[i] = {ry_q[i-1], ly_q[i-1][QW-1]};
      if (tx[i] >= {1'b0, div_x}) begin
        rx_d[i] = RW'(tx[i] - {1'b0, div_x});
        lx_d[i] = {lx_q[i-1][QW-2:0], 1'b1};
      end else begin
        rx_d[i] = RW'(tx[i]);
        lx_d[i] = {lx_q[i-1][QW-2:0], 1'b0};
      end
      if (ty[i] >= {1'b0, div_y}) begin
        ry_d[i] = RW'(ty[i] - {1'b0, div_y});
        ly_d[i] = {ly_q[i-1][QW-2:0], 1'b1};
      end else begin
        ry_d[i] = RW'(ty[i]);
        ly_d[i] = {ly_q[i-1][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= QW; i++) begin
        pv_q[i] <= 1'b0;
      end
    end else if (adv) begin
      pv_q[0] <= in_valid_i;
      for (int i = 1; i <= QW; i++) begin
        pv_q[i] <= pv_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pitem_q[0] <= in_item_i;
      rx_q[0]    <= ext_x[QW+RW-1:QW];
      lx_q[0]    <= ext_x[QW-1:0];
      ry_q[0]    <= ext_y[QW+RW-1:QW];
      ly_q[0]    <= ext_y[QW-1:0];
      for (int i = 1; i <= QW; i++) begin
        pitem_q[i] <= pitem_q[i-1];
        rx_q[i]    <= rx_d[i];
        lx_q[i]    <= lx_d[i];
        ry_q[i]    <= ry_d[i];
        ly_q[i]    <= ly_d[i];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Neighbour indices and fractions from the quotients
  // ---------------------------------------------------------------------------
  logic [QW-1:0] half_fix;
  logic [QW-1:0] sx, sy;
  logic [IW-1:0] ix, iy, swm1, shm1, cx0, cy0, cx1, cy1;
  in_item_t      pend;
  logic          pend_oor, pend_ld_ok;

  assign half_fix = QW'(1) << (F - 1);
  assign pend     = pitem_q[QW];

  always_comb begin
    sx   = (lx_q[QW] > half_fix) ? (lx_q[QW] - half_fix) : '0;
    sy   = (ly_q[QW] > half_fix) ? (ly_q[QW] - half_fix) : '0;
    ix   = sx[QW-1:F];
    iy   = sy[QW-1:F];
    swm1 = IW'(sw_eff) - IW'(1);
    shm1 = IW'(sh_eff) - IW'(1);
    cx0  = (ix > swm1) ? swm1 : ix;
    cy0  = (iy > shm1) ? shm1 : iy;
    cx1  = ((cx0 + IW'(1)) < IW'(sw_eff)) ? (cx0 + IW'(1)) : cx0;
    cy1  = ((cy0 + IW'(1)) < IW'(sh_eff)) ? (cy0 + IW'(1)) : cy0;
    pend_oor   = (32'(pend.pos_x) >= 32'(tw_eff)) || (32'(pend.pos_y) >= 32'(th_eff));
    pend_ld_ok = (32'(pend.pos_x) < 32'(MAX_SOURCE_WIDTH)) &&
                 (32'(pend.pos_y) < 32'(MAX_SOURCE_HEIGHT));
  end

  // ---------------------------------------------------------------------------
  // Memory sequencer: one access per cycle while not stalled, four reads per sample
  // ---------------------------------------------------------------------------
  logic             be_en;      // memory side advances
  logic             s_v_q;
  logic [1:0]       s_k_q;
  logic             s_sample_q, s_oor_q, s_ld_ok_q;
  logic [XW-1:0]    s_x0_q, s_x1_q;
  logic [YW-1:0]    s_y0_q, s_y1_q;
  logic [F-1:0]     s_fx_q, s_fy_q;
  logic [PIX_W-1:0] s_pix_q;
  logic             s_last;

  logic             out_v_q;
  out_item_t        out_q;

  assign be_en  = !out_v_q || !out_stall_i;
  assign s_last = !s_sample_q || (s_k_q == 2'd3);
  assign take   = be_en && (!s_v_q || s_last);
  assign adv    = !pv_q[QW] || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_v_q <= 1'b0;
      s_k_q <= '0;
    end else if (take) begin
      s_v_q <= pv_q[QW];
      s_k_q <= '0;
    end else if (be_en && s_v_q) begin
      s_k_q <= s_k_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s_sample_q <= (pend.req_type == REQ_SAMPLE);
      s_oor_q    <= pend_oor;
      s_ld_ok_q  <= pend_ld_ok;
      s_pix_q    <= {pend.pixel_red, pend.pixel_green, pend.pixel_blue};
      s_fx_q     <= sx[F-1:0];
      s_fy_q     <= sy[F-1:0];
      if (pend.req_type == REQ_SAMPLE) begin
        s_x0_q <= XW'(cx0);
        s_x1_q <= XW'(cx1);
        s_y0_q <= YW'(cy0);
        s_y1_q <= YW'(cy1);
      end else begin
        s_x0_q <= XW'(pend.pos_x);
        s_x1_q <= XW'(pend.pos_x);
        s_y0_q <= YW'(pend.pos_y);
        s_y1_q <= YW'(pend.pos_y);
      end
    end
  end

  // Neighbour order: bit 0 of the step picks column x1, bit 1 picks row y1
  logic [XW-1:0]    sel_x;
  logic [YW-1:0]    sel_y;
  logic [AW-1:0]    ram_addr;
  logic             ram_en, ram_we;
  logic [PIX_W-1:0] ram_rdata;
  logic [F:0]       wa, wb;

  always_comb begin
    sel_x    = s_k_q[0] ? s_x1_q : s_x0_q;
    sel_y    = s_k_q[1] ? s_y1_q : s_y0_q;
    ram_addr = AW'(AW'(sel_y) * AW'(MAX_SOURCE_WIDTH)) + AW'(sel_x);
    ram_we   = !s_sample_q;
    ram_en   = be_en && s_v_q && (s_sample_q || s_ld_ok_q);
    wa       = s_k_q[0] ? {1'b0, s_fx_q} : ((F+1)'(1) << F) - {1'b0, s_fx_q};
    wb       = s_k_q[1] ? {1'b0, s_fy_q} : ((F+1)'(1) << F) - {1'b0, s_fy_q};
  end

  brs_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_image (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (s_pix_q),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Blend: weight registered alongside the read, while not stalled accumulate one neighbour a cycle
  // ---------------------------------------------------------------------------
  logic          m_v_q, m_last_q, m_first_q, m_oor_q;
  logic [WW-1:0] w_q;
  logic [AC-1:0] acc_q [3];
  logic          fin_v_q, fin_oor_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_v_q   <= 1'b0;
      fin_v_q <= 1'b0;
    end else if (be_en) begin
      m_v_q   <= s_v_q && s_sample_q;
      fin_v_q <= m_v_q && m_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (be_en) begin
      w_q       <= WW'(wa) * WW'(wb);
      m_last_q  <= (s_k_q == 2'd3);
      m_first_q <= (s_k_q == 2'd0);
      m_oor_q   <= s_oor_q;
      fin_oor_q <= m_oor_q;
      if (m_v_q) begin
        for (int c = 0; c < 3; c++) begin
          acc_q[c] <= (m_first_q ? AC'(0) : acc_q[c]) +
                      AC'(ram_rdata[PIX_W-1-COLOUR_W*c -: COLOUR_W]) * AC'(w_q);
        end
      end
    end
  end

  // Round half up once, then saturate
  logic [AC-1:0]       rnd  [3];
  logic [COLOUR_W-1:0] chan [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rnd[c] = acc_q[c] + (AC'(1) << (2 * F - 1));
      if (rnd[c][AC-1:2*F] > RNDW'(255)) chan[c] = COLOUR_W'(255);
      else chan[c] = COLOUR_W'(rnd[c][AC-1:2*F]);
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (be_en) begin
      out_v_q <= fin_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (be_en && fin_v_q) begin
      if (fin_oor_q) begin
        out_q.out_red   <= '0;
        out_q.out_green <= '0;
        out_q.out_blue  <= '0;
        out_q.status    <= STATUS_RANGE;
      end else begin
        out_q.out_red   <= chan[0];
        out_q.out_green <= chan[1];
        out_q.out_blue  <= chan[2];
        out_q.status    <= STATUS_OK;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import brs_pkg::*;

  localparam int unsigned SRC_MAX   = 256;
  localparam int unsigned TGT_MAX   = 1024;
  localparam int unsigned FRAC      = 16;
  // Settling margin after the expected results have drained
  localparam int unsigned SETTLE    = 120;
  localparam int unsigned HOLD_LONG = 400;

  // One row of the directed part: either a register write or an item,
  // optionally with the result typed in by hand
  typedef struct {
    bit        is_cfg;
    cfg_idx_e  idx;
    int        data;
    in_item_t  it;
    bit        fixed;
    out_item_t res;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Shadow of the block: size registers and the source image
  int unsigned src_w_reg, src_h_reg, tgt_w_reg, tgt_h_reg;
  logic [23:0] image_mem [SRC_MAX*SRC_MAX];
  bit          loaded [SRC_MAX*SRC_MAX];

  out_item_t pixel_q [$];
  int        errors = 0;
  int        sent = 0;
  bit        send_calm = 1'b0;
  bit        recv_calm = 1'b0;
  bit        pressure_req = 1'b0;
  bit        pressure_done = 1'b0;
  int        hold_cnt = 0;

  bilinear_rgb_image_scaler_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned eff_size(int unsigned v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Fixed-point source coordinate with FRAC fraction bits, clamped at zero
  function automatic longint unsigned source_coord(int unsigned d, int unsigned src,
                                                   int unsigned dst);
    longint unsigned num, q;
    num = (longint'(2 * d + 1) * longint'(src)) << FRAC;
    q = num / (2 * longint'(dst));
    return (q > (64'd1 << (FRAC - 1))) ? q - (64'd1 << (FRAC - 1)) : 64'd0;
  endfunction

  // Neighbour columns/rows and fractions for one destination pixel
  function automatic void neighbours(input int unsigned dx, dy,
                                     output int unsigned x0, x1, y0, y1,
                                     output longint unsigned fx, fy);
    int unsigned     sw, sh, tw, th;
    longint unsigned sx, sy;
    sw = eff_size(src_w_reg, SRC_MAX);
    sh = eff_size(src_h_reg, SRC_MAX);
    tw = eff_size(tgt_w_reg, TGT_MAX);
    th = eff_size(tgt_h_reg, TGT_MAX);
    sx = source_coord(dx, sw, tw);
    sy = source_coord(dy, sh, th);
    fx = sx & ((64'd1 << FRAC) - 1);
    fy = sy & ((64'd1 << FRAC) - 1);
    x0 = ((sx >> FRAC) > sw - 1) ? sw - 1 : int'(sx >> FRAC);
    y0 = ((sy >> FRAC) > sh - 1) ? sh - 1 : int'(sy >> FRAC);
    x1 = (x0 + 1 < sw) ? x0 + 1 : x0;
    y1 = (y0 + 1 < sh) ? y0 + 1 : y0;
  endfunction

  function automatic bit in_target(int unsigned dx, dy);
    return dx < eff_size(tgt_w_reg, TGT_MAX) && dy < eff_size(tgt_h_reg, TGT_MAX);
  endfunction

  function automatic out_item_t scaled_pixel(int unsigned dx, dy);
    out_item_t       r;
    int unsigned     x0, x1, y0, y1, sh_c;
    longint unsigned fx, fy, one, w00, w01, w10, w11, acc, v;
    logic [23:0]     p00, p01, p10, p11;
    r = '0;
    if (!in_target(dx, dy)) begin
      r.status = STATUS_RANGE;
      return r;
    end
    neighbours(dx, dy, x0, x1, y0, y1, fx, fy);
    one = 64'd1 << FRAC;
    p00 = image_mem[y0 * SRC_MAX + x0];
    p01 = image_mem[y0 * SRC_MAX + x1];
    p10 = image_mem[y1 * SRC_MAX + x0];
    p11 = image_mem[y1 * SRC_MAX + x1];
    w00 = (one - fx) * (one - fy);
    w01 = fx * (one - fy);
    w10 = (one - fx) * fy;
    w11 = fx * fy;
    for (int c = 0; c < 3; c++) begin
      sh_c = 16 - 8 * c;
      acc = longint'((p00 >> sh_c) & 8'hff) * w00 + longint'((p01 >> sh_c) & 8'hff) * w01
          + longint'((p10 >> sh_c) & 8'hff) * w10 + longint'((p11 >> sh_c) & 8'hff) * w11;
      v = (acc + (64'd1 << (2 * FRAC - 1))) >> (2 * FRAC);
      if (v > 255) v = 255;
      case (c)
        0: r.out_red = v[7:0];
        1: r.out_green = v[7:0];
        default: r.out_blue = v[7:0];
      endcase
    end
    r.status = STATUS_OK;
    return r;
  endfunction

  // Mostly short gaps, a few long ones, none while the sender is calm
  function automatic int gap_len(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one item, hold it until taken, then update the shadow image or queue the expected result
  task automatic drive_item(input in_item_t it, input bit fixed, input out_item_t res);
    int g;
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    sent++;
    if (it.req_type == REQ_LOAD) begin
      if (it.pos_x < SRC_MAX && it.pos_y < SRC_MAX) begin
        image_mem[it.pos_y * SRC_MAX + it.pos_x] = {it.pixel_red, it.pixel_green,
                                                    it.pixel_blue};
        loaded[it.pos_y * SRC_MAX + it.pos_x] = 1'b1;
      end
    end else begin
      pixel_q.push_back(fixed ? res : scaled_pixel(it.pos_x, it.pos_y));
    end
    g = gap_len(send_calm);
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Load any neighbour not yet written, so no in-target sample reads an unwritten entry
  task automatic fill_neighbours(input int unsigned dx, dy);
    int unsigned     xs [4], ys [4];
    longint unsigned fx, fy;
    in_item_t        ld;
    if (!in_target(dx, dy)) return;
    neighbours(dx, dy, xs[0], xs[1], ys[0], ys[2], fx, fy);
    xs[2] = xs[0]; xs[3] = xs[1]; ys[1] = ys[0]; ys[3] = ys[2];
    for (int k = 0; k < 4; k++) begin
      if (!loaded[ys[k] * SRC_MAX + xs[k]]) begin
        ld = '{REQ_LOAD, xs[k][9:0], ys[k][9:0], 8'($urandom), 8'($urandom), 8'($urandom)};
        drive_item(ld, 1'b0, '0);
      end
    end
  endtask

  // Drop valid and let every outstanding sample come out, then settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_size(input cfg_idx_e idx, input int unsigned val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SOURCE_WIDTH:  src_w_reg = val & 32'h1ff;
      CFG_SOURCE_HEIGHT: src_h_reg = val & 32'h1ff;
      CFG_TARGET_WIDTH:  tgt_w_reg = val & 32'h7ff;
      default:           tgt_h_reg = val & 32'h7ff;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // Size value for one register: extremes often, otherwise anything in range
  function automatic int unsigned pick_size(int unsigned maxv, int unsigned field_max);
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 1;
      2: return maxv;
      3: return $urandom_range(maxv + 1, field_max);
      4: return $urandom_range(1, 8);
      default: return $urandom_range(1, maxv);
    endcase
  endfunction

  // Result side: check each taken item, then choose the next stall value
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected item %h", $time, out_item);
          errors++;
        end else begin
          want = pixel_q.pop_front();
          if (out_item.out_red !== want.out_red) begin
            $display("%0t: red expected %h actual %h", $time, want.out_red, out_item.out_red);
            errors++;
          end
          if (out_item.out_green !== want.out_green) begin
            $display("%0t: green expected %h actual %h", $time, want.out_green,
                     out_item.out_green);
            errors++;
          end
          if (out_item.out_blue !== want.out_blue) begin
            $display("%0t: blue expected %h actual %h", $time, want.out_blue,
                     out_item.out_blue);
            errors++;
          end
          if (out_item.status !== want.status) begin
            $display("%0t: status expected %b actual %b", $time, want.status,
                     out_item.status);
            errors++;
          end
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else if (pressure_req && !pressure_done) begin
        // Long hold-off so the block backs up and stalls its input
        pressure_done = 1'b1;
        hold_cnt = HOLD_LONG;
        out_stall <= 1'b1;
      end else if (recv_calm) begin
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < 3) begin
        hold_cnt = $urandom_range(8, 40);
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < 25);
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    row_t        tbl [$];
    in_item_t    it;
    int          stop_at;

    src_w_reg = 256; src_h_reg = 256; tgt_w_reg = 1024; tgt_h_reg = 1024;
    foreach (loaded[i]) loaded[i] = 1'b0;

    // Reset sizes, corners, ignored loads
    tbl.push_back('{0, CFG_SOURCE_WIDTH, 0, '{REQ_SAMPLE, 10'd0, 10'd0, 8'd0, 8'd0, 8'd0},
                  0, '0});
    tbl.push_back('{0, CFG_SOURCE_WIDTH, 0, '{REQ_SAMPLE, 10'd1023, 10'd1023, 8'd0, 8'd0,
                  8'd0}, 0, '0});
    tbl.push_back('{0, CFG_SOURCE_WIDTH, 0, '{REQ_LOAD, 10'd0, 10'd0, 8'h00, 8'h00, 8'h00},
                  0, '0});
    tbl.push_back('{0, CFG_SOURCE_WIDTH, 0, '{REQ_LOAD, 10'd255, 10'd255, 8'hff, 8'hff,
                  8'hff}, 0, '0});
    tbl.push_back('{0, CFG_SOURCE_WIDTH, 0, '{REQ_LOAD, 10'd256, 10'd3, 8'h55, 8'haa, 8'h5a},
                  0, '0});
    tbl.push_back('{0, CFG_SOURCE_WIDTH, 0, '{REQ_LOAD, 10'd1023, 10'd1023, 8'hff, 8'hff,
                  8'hff}, 0, '0});
    tbl.push_back('{0, CFG_SOURCE_WIDTH, 0, '{REQ_SAMPLE, 10'd0, 10'd0, 8'hff, 8'hff, 8'hff},
                  0, '0});
    tbl.push_back('{0, CFG_SOURCE_WIDTH, 0, '{REQ_SAMPLE, 10'd1023, 10'd1023, 8'hff, 8'hff,
                  8'hff}, 0, '0});
    // Small target: coordinates outside it give the range status
    tbl.push_back('{1, CFG_SOURCE_WIDTH, 1, '0, 0, '0});
    tbl.push_back('{1, CFG_SOURCE_HEIGHT, 1, '0, 0, '0});
    tbl.push_back('{1, CFG_TARGET_WIDTH, 5, '0, 0, '0});
    tbl.push_back('{1, CFG_TARGET_HEIGHT, 7, '0, 0, '0});
    tbl.push_back('{0, CFG_SOURCE_WIDTH, 0, '{REQ_SAMPLE, 10'd5, 10'd0, 8'd0, 8'd0, 8'd0},
                  1, '{8'd0, 8'd0, 8'd0, STATUS_RANGE}});
    tbl.push_back('{0, CFG_SOURCE_WIDTH, 0, '{REQ_SAMPLE, 10'd0, 10'd7, 8'd0, 8'd0, 8'd0},
                  1, '{8'd0, 8'd0, 8'd0, STATUS_RANGE}});
    tbl.push_back('{0, CFG_SOURCE_WIDTH, 0, '{REQ_SAMPLE, 10'd1023, 10'd1023, 8'd0, 8'd0,
                  8'd0}, 1, '{8'd0, 8'd0, 8'd0, STATUS_RANGE}});
    tbl.push_back('{0, CFG_SOURCE_WIDTH, 0, '{REQ_SAMPLE, 10'd4, 10'd6, 8'd0, 8'd0, 8'd0},
                  0, '0});
    // Zero sizes act as one
    tbl.push_back('{1, CFG_TARGET_WIDTH, 0, '0, 0, '0});
    tbl.push_back('{1, CFG_TARGET_HEIGHT, 0, '0, 0, '0});
    tbl.push_back('{0, CFG_SOURCE_WIDTH, 0, '{REQ_SAMPLE, 10'd0, 10'd0, 8'd0, 8'd0, 8'd0},
                  0, '0});
    tbl.push_back('{0, CFG_SOURCE_WIDTH, 0, '{REQ_SAMPLE, 10'd1, 10'd0, 8'd0, 8'd0, 8'd0},
                  1, '{8'd0, 8'd0, 8'd0, STATUS_RANGE}});
    // Oversized sizes act as the maximum
    tbl.push_back('{1, CFG_SOURCE_WIDTH, 511, '0, 0, '0});
    tbl.push_back('{1, CFG_SOURCE_HEIGHT, 511, '0, 0, '0});
    tbl.push_back('{1, CFG_TARGET_WIDTH, 2047, '0, 0, '0});
    tbl.push_back('{1, CFG_TARGET_HEIGHT, 2047, '0, 0, '0});
    tbl.push_back('{0, CFG_SOURCE_WIDTH, 0, '{REQ_SAMPLE, 10'd1023, 10'd1023, 8'd0, 8'd0,
                  8'd0}, 0, '0});

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (tbl[i]) begin
      if (tbl[i].is_cfg) begin
        write_size(tbl[i].idx, tbl[i].data);
      end else begin
        if (tbl[i].it.req_type == REQ_SAMPLE) fill_neighbours(tbl[i].it.pos_x, tbl[i].it.pos_y);
        drive_item(tbl[i].it, tbl[i].fixed, tbl[i].res);
      end
    end

    // Random phases, each with its own sizes; neighbour loads count towards the budget
    for (int ph = 0; ph < 10; ph++) begin
      write_size(CFG_SOURCE_WIDTH, pick_size(SRC_MAX, 511));
      write_size(CFG_SOURCE_HEIGHT, pick_size(SRC_MAX, 511));
      write_size(CFG_TARGET_WIDTH, pick_size(TGT_MAX, 2047));
      write_size(CFG_TARGET_HEIGHT, pick_size(TGT_MAX, 2047));
      send_calm = (ph == 1) || (ph == 6);
      recv_calm = (ph == 4);
      if (ph == 1) pressure_req = 1'b1;
      stop_at = sent + 155;
      while (sent < stop_at) begin
        it = in_item_t'({$urandom, $urandom});
        if ($urandom_range(0, 99) < 25) begin
          it.req_type = REQ_LOAD;
          if ($urandom_range(0, 99) < 80) begin
            it.pos_x = POS_W'($urandom_range(0, SRC_MAX - 1));
            it.pos_y = POS_W'($urandom_range(0, SRC_MAX - 1));
          end
        end else begin
          it.req_type = REQ_SAMPLE;
          if ($urandom_range(0, 99) < 85) begin
            it.pos_x = POS_W'($urandom_range(0, eff_size(tgt_w_reg, TGT_MAX) - 1));
            it.pos_y = POS_W'($urandom_range(0, eff_size(tgt_h_reg, TGT_MAX) - 1));
          end
          fill_neighbours(it.pos_x, it.pos_y);
        end
        drive_item(it, 1'b0, '0);
      end
    end

    drain();
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
